>>> hw/rtl/pese_pkg.sv
// shared constants, token codes and controller/datapath interface types
// for the prefix expression stack evaluator; no dependencies
package pese_pkg;

    localparam int WORD_W      = 16;
    localparam int STACK_DEPTH = 32;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int DIV_CNT_W   = $clog2(WORD_W + 1);

    // token kinds
    localparam logic [1:0] KIND_OPERAND  = 2'd0;
    localparam logic [1:0] KIND_OPERATOR = 2'd1;
    localparam logic [1:0] KIND_END      = 2'd2;

    // operator codes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MOD = 3'd4;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_DIV0  = 2'd1;
    localparam logic [1:0] ERR_OVER  = 2'd2;
    localparam logic [1:0] ERR_UNDER = 2'd3;

    typedef logic signed [WORD_W-1:0] word_t;

    // controller to datapath commands
    typedef struct packed {
        logic latch_op;   // store opcode of an accepted operator word
        logic push_in;    // push the operand of the accepted word
        logic pop;        // pop top of stack into the read register
        logic cap_a;      // capture popped value as first operand
        logic exec;       // second operand popped, run alu or start divider
        logic div_res;    // capture divider result
        logic push_res;   // push the operator result
        logic finish;     // load result word, clear stack and error
    } pese_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_div;     // held opcode is divide or modulo
        logic div_zero;   // popped second operand is zero
        logic div_done;   // divider finished
        logic out_free;   // output register can take a result word
    } pese_sts_t;

endpackage

>>> hw/rtl/pese_div.sv
// 16-step restoring signed divider, one quotient bit per cycle
// depends on pese_pkg
module pese_div (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  pese_pkg::word_t dividend,
    input  pese_pkg::word_t divisor,
    output logic          done,
    output pese_pkg::word_t quotient,
    output pese_pkg::word_t remainder
);
    import pese_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [WORD_W-1:0]    dvd_reg, dvd_next;
    logic [WORD_W-1:0]    rem_reg, rem_next;
    logic [WORD_W-1:0]    dvs_reg, dvs_next;
    logic                 neg_q_reg, neg_q_next;
    logic                 neg_r_reg, neg_r_next;

    logic [WORD_W-1:0]    a_mag, b_mag;
    logic [WORD_W:0]      shifted, diff;
    logic                 ge;

    assign a_mag   = dividend[WORD_W-1] ? (WORD_W)'(-dividend) : dividend;
    assign b_mag   = divisor[WORD_W-1]  ? (WORD_W)'(-divisor)  : divisor;
    assign shifted = {rem_reg, dvd_reg[WORD_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb begin
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        if (start) begin
            cnt_next   = DIV_CNT_W'(WORD_W);
            dvd_next   = a_mag;
            rem_next   = '0;
            dvs_next   = b_mag;
            neg_q_next = dividend[WORD_W-1] ^ divisor[WORD_W-1];
            neg_r_next = dividend[WORD_W-1];
        end else if (cnt_reg != '0) begin
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            done_next = (cnt_reg == DIV_CNT_W'(1));
            rem_next  = ge ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
            dvd_next  = {dvd_reg[WORD_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    assign done      = done_reg;
    assign quotient  = neg_q_reg ? word_t'(-dvd_reg) : word_t'(dvd_reg);
    assign remainder = neg_r_reg ? word_t'(-rem_reg) : word_t'(rem_reg);

endmodule

>>> hw/rtl/pese_dp.sv
// datapath: operand stack memory, depth and sticky error, alu, divider,
// output register; depends on pese_pkg and pese_div
module pese_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  pese_pkg::word_t     s_operand_value,
    input  logic [2:0]          s_opcode,
    input  pese_pkg::pese_cmd_t cmd,
    output pese_pkg::pese_sts_t sts,
    input  logic                m_ready,
    output logic                m_valid,
    output pese_pkg::word_t     m_result_value,
    output logic [1:0]          m_error_code
);
    import pese_pkg::*;

    word_t               stack_mem [STACK_DEPTH];
    word_t               rd_data_reg;

    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [1:0]          sticky_reg, sticky_next;
    logic                empty_pop_reg, empty_pop_next;
    logic [2:0]          opcode_reg;
    word_t               a_reg;
    word_t               res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    word_t               m_result_reg;
    logic [1:0]          m_error_reg;

    logic [DEPTH_W-1:0]  depth_m1;
    logic                empty, full;
    logic                push;
    word_t               push_data;
    word_t               pop_val;
    logic signed [2*WORD_W-1:0] prod;
    word_t               alu_res;
    logic                flag;
    logic [1:0]          flag_code;
    logic                div_start;
    word_t               div_quo, div_rem;
    logic                div_done;

    assign depth_m1  = depth_reg - DEPTH_W'(1);
    assign empty     = (depth_reg == '0);
    assign full      = (depth_reg == DEPTH_W'(STACK_DEPTH));
    assign push      = cmd.push_in || cmd.push_res;
    assign push_data = cmd.push_in ? s_operand_value : res_reg;
    assign pop_val   = empty_pop_reg ? word_t'(0) : rd_data_reg;

    assign sts.is_div   = (opcode_reg == OP_DIV) || (opcode_reg == OP_MOD);
    assign sts.div_zero = (pop_val == word_t'(0));
    assign sts.div_done = div_done;
    assign sts.out_free = !m_valid_reg || m_ready;

    assign div_start = cmd.exec && sts.is_div && !sts.div_zero;

    pese_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (a_reg),
        .divisor   (pop_val),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // low half of the product is the wrapped 16-bit result
    assign prod = a_reg * pop_val;

    always_comb begin
        case (opcode_reg)
            OP_ADD:  alu_res = a_reg + pop_val;
            OP_SUB:  alu_res = a_reg - pop_val;
            OP_MUL:  alu_res = prod[WORD_W-1:0];
            default: alu_res = '0;
        endcase
    end

    // error sources; only the first since the last end word is kept
    always_comb begin
        flag      = 1'b0;
        flag_code = ERR_NONE;
        if (cmd.pop && empty) begin
            flag      = 1'b1;
            flag_code = ERR_UNDER;
        end
        if (push && full) begin
            flag      = 1'b1;
            flag_code = ERR_OVER;
        end
        if (cmd.exec && sts.is_div && sts.div_zero) begin
            flag      = 1'b1;
            flag_code = ERR_DIV0;
        end
    end

    always_comb begin
        depth_next     = depth_reg;
        sticky_next    = sticky_reg;
        empty_pop_next = empty_pop_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        if (flag && sticky_reg == ERR_NONE) begin
            sticky_next = flag_code;
        end
        if (cmd.pop) begin
            empty_pop_next = empty;
            if (!empty) begin
                depth_next = depth_m1;
            end
        end
        if (push && !full) begin
            depth_next = depth_reg + DEPTH_W'(1);
        end
        if (cmd.exec) begin
            res_next = alu_res;
        end
        if (cmd.div_res) begin
            res_next = (opcode_reg == OP_MOD) ? div_rem : div_quo;
        end
        if (cmd.finish) begin
            depth_next   = '0;
            sticky_next  = ERR_NONE;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg     <= '0;
            sticky_reg    <= ERR_NONE;
            empty_pop_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            depth_reg     <= depth_next;
            sticky_reg    <= sticky_next;
            empty_pop_reg <= empty_pop_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // stack memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (push && !full) begin
            stack_mem[depth_reg[PTR_W-1:0]] <= push_data;
        end
        if (cmd.pop) begin
            rd_data_reg <= stack_mem[depth_m1[PTR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (cmd.latch_op) begin
            opcode_reg <= s_opcode;
        end
        if (cmd.cap_a) begin
            a_reg <= pop_val;
        end
        if (cmd.finish) begin
            m_result_reg <= pop_val;
            m_error_reg  <= sticky_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_reg;
    assign m_error_code   = m_error_reg;

endmodule

>>> hw/rtl/pese_ctrl.sv
// controller state machine: sequences pops, alu or divider and push per word
// depends on pese_pkg
module pese_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic [1:0]          s_kind,
    input  logic [2:0]          s_opcode,
    input  pese_pkg::pese_sts_t sts,
    output logic                s_ready,
    output pese_pkg::pese_cmd_t cmd
);
    import pese_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_POP2 = 6'b000010,
        ST_OPS  = 6'b000100,
        ST_DIVW = 6'b001000,
        ST_PUSH = 6'b010000,
        ST_END  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = (state_reg == ST_IDLE);
        accept     = s_valid && s_ready;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_kind)
                        KIND_OPERAND: begin
                            cmd.push_in = 1'b1;
                        end
                        KIND_OPERATOR: begin
                            if (s_opcode <= OP_MOD) begin
                                cmd.latch_op = 1'b1;
                                cmd.pop      = 1'b1;
                                state_next   = ST_POP2;
                            end
                        end
                        KIND_END: begin
                            cmd.pop    = 1'b1;
                            state_next = ST_END;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_POP2: begin
                cmd.cap_a  = 1'b1;
                cmd.pop    = 1'b1;
                state_next = ST_OPS;
            end
            ST_OPS: begin
                cmd.exec   = 1'b1;
                state_next = (sts.is_div && !sts.div_zero) ? ST_DIVW : ST_PUSH;
            end
            ST_DIVW: begin
                if (sts.div_done) begin
                    cmd.div_res = 1'b1;
                    state_next  = ST_PUSH;
                end
            end
            ST_PUSH: begin
                cmd.push_res = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_END: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/prefix_expression_stack_evaluator.sv
// Prefix expression evaluator with a 32-word operand stack. Tokens arrive as
// words on the s_ channel from the last token of the expression to the first:
// an operand word (kind 0) pushes its 16-bit signed value, an operator word
// (kind 1) pops the first operand, then the second, computes first op second
// with 16-bit wraparound (divide truncates toward zero, the remainder takes
// the dividend's sign) and pushes the result, and an end word (kind 2) pops
// the final value and sends it on the m_ channel with the first error seen
// since the previous end word, then empties the stack. Underflow pops give 0,
// pushes onto a full stack are dropped, division or modulo by zero gives 0,
// each flagging its error code. Operator codes 5 to 7 and kind 3 are ignored.
// Steps: an operand word is pushed as it is taken; an operator word goes
// through the pop, pop, execute, optional divider wait (the 16-step
// one-bit-per-cycle divider) and push states; an end word pops and then
// waits until the output register is free. The stack is a single-port-read
// memory, so an operator's two pops are done in separate states. The result
// sits in an output register, so new words are taken while it waits on m_ready.
// depends on pese_pkg, pese_ctrl, pese_dp
module prefix_expression_stack_evaluator (
    input  logic              aclk,
    input  logic              aresetn,
    // token input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_kind,
    input  pese_pkg::word_t   s_operand_value,
    input  logic [2:0]        s_opcode,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output pese_pkg::word_t   m_result_value,
    output logic [1:0]        m_error_code
);
    import pese_pkg::*;

    // command and status between controller and datapath
    pese_cmd_t cmd;
    pese_sts_t sts;

    // controller: decodes the accepted word and steps through pop, pop,
    // execute, optional divider wait and push
    pese_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_kind   (s_kind),
        .s_opcode (s_opcode),
        .sts      (sts),
        .s_ready  (s_ready),
        .cmd      (cmd)
    );

    // datapath: stack memory, depth counter, sticky error, alu, divider
    // and the output register
    pese_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_operand_value (s_operand_value),
        .s_opcode        (s_opcode),
        .cmd             (cmd),
        .sts             (sts),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_result_value  (m_result_value),
        .m_error_code    (m_error_code)
    );

    // an operator result push never overlaps with taking a new word
    a_push_res_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push_res |-> !s_ready)
        else $error("operator push while input ready");

    // a result never overwrites one that has not been taken
    a_finish_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_valid || m_ready))
        else $error("result overwritten");

    // finishing an expression always presents a result next cycle
    a_finish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid)
        else $error("finished expression without result");

    // the divider only completes while its result is waited for
    a_div_done_used: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> cmd.div_res)
        else $error("divider result not captured");

endmodule

>>> bench/tb.sv
// self-checking bench for prefix_expression_stack_evaluator: directed and random
// token streams, every result word checked against an in-bench stack evaluator
// depends on pese_pkg and the evaluator rtl

module tb;

    import pese_pkg::*;

    typedef struct {
        word_t      value;
        logic [1:0] err;
    } eval_result_t;

    // tracks the evaluator's stack and sticky error, queues the result word of
    // each end token and compares the words that come out
    class prefix_eval_model;
        word_t        stack_words [STACK_DEPTH];
        int unsigned  depth;
        logic [1:0]   held_error;
        eval_result_t expected_results [$];
        int unsigned  fail_count;
        int unsigned  checked_count;
        int unsigned  error_tally [4];

        function new();
            depth = 0;
            held_error = ERR_NONE;
            fail_count = 0;
            checked_count = 0;
            foreach (error_tally[i]) error_tally[i] = 0;
        endfunction

        // first error since the last end token wins
        function void flag_error(logic [1:0] code);
            if (held_error == ERR_NONE) held_error = code;
        endfunction

        function void push_word(word_t value);
            if (depth >= STACK_DEPTH) begin
                flag_error(ERR_OVER);
            end else begin
                stack_words[depth] = value;
                depth++;
            end
        endfunction

        function word_t pop_word();
            if (depth == 0) begin
                flag_error(ERR_UNDER);
                return '0;
            end
            depth--;
            return stack_words[depth];
        endfunction

        // 32-bit math, wrapped back to the word width on return
        function word_t apply_operator(logic [2:0] op, word_t a_val, word_t b_val);
            int lhs, rhs, res;
            lhs = a_val;
            rhs = b_val;
            res = 0;
            case (op)
                OP_ADD: res = lhs + rhs;
                OP_SUB: res = lhs - rhs;
                OP_MUL: res = lhs * rhs;
                OP_DIV: begin
                    if (rhs == 0) flag_error(ERR_DIV0);
                    else res = lhs / rhs;
                end
                default: begin
                    if (rhs == 0) flag_error(ERR_DIV0);
                    else res = lhs % rhs;
                end
            endcase
            return word_t'(res);
        endfunction

        function void take_token(logic [1:0] kind, word_t value, logic [2:0] opcode);
            word_t        a_val, b_val;
            eval_result_t res;
            case (kind)
                KIND_OPERAND: push_word(value);
                KIND_OPERATOR: begin
                    if (opcode <= OP_MOD) begin
                        a_val = pop_word();
                        b_val = pop_word();
                        push_word(apply_operator(opcode, a_val, b_val));
                    end
                end
                KIND_END: begin
                    res.value = pop_word();
                    res.err = held_error;
                    expected_results.push_back(res);
                    depth = 0;
                    held_error = ERR_NONE;
                end
                default: ;
            endcase
        endfunction

        function void check_result(word_t value, logic [1:0] err);
            eval_result_t want;
            if (expected_results.size() == 0) begin
                $error("result word with nothing pending: value %0d, error %0d",
                       value, err);
                fail_count++;
                return;
            end
            want = expected_results.pop_front();
            checked_count++;
            error_tally[want.err]++;
            if (value !== want.value) begin
                $error("result_value: expected %0d, got %0d", want.value, value);
                fail_count++;
            end
            if (err !== want.err) begin
                $error("error_code: expected %0d, got %0d", want.err, err);
                fail_count++;
            end
        endfunction

        function int unsigned outstanding();
            return expected_results.size();
        endfunction
    endclass

    // token codes the block ignores
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [2:0] OP_UNDEF_LO = 3'd5;
    localparam logic [2:0] OP_UNDEF_HI = 3'd7;

    localparam word_t       WORD_MAX      = 16'sh7fff;
    localparam word_t       WORD_MIN      = 16'sh8000;
    localparam int          TX_ITEMS      = 1900;
    localparam int          MAX_IDLE      = 12;
    localparam int          SETTLE_CYCLES = 64;
    // run bound that allows for divides plus full gaps and stalls
    localparam int unsigned CYCLE_LIMIT   = 400000;

    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic [1:0] s_kind          = KIND_OPERAND;
    word_t      s_operand_value = '0;
    logic [2:0] s_opcode        = OP_ADD;
    logic       m_valid;
    logic       m_ready         = 1'b0;
    word_t      m_result_value;
    logic [1:0] m_error_code;

    prefix_eval_model eval_model;
    int unsigned      token_count = 0;
    int unsigned      cycle_count = 0;
    bit               tx_burst    = 1'b0;
    bit               rx_burst    = 1'b0;
    bit               paused_once = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    prefix_expression_stack_evaluator u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_operand_value (s_operand_value),
        .s_opcode        (s_opcode),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_value  (m_result_value),
        .m_error_code    (m_error_code)
    );

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result words are taken at the rising edge where valid and ready meet
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            eval_model.check_result(m_result_value, m_error_code);
    end

    // result side: a random stall before each word, with stretches of none
    initial begin
        int unsigned stall;
        wait (aresetn);
        forever begin
            if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
            repeat (stall) @(negedge aclk) m_ready <= 1'b0;
            @(negedge aclk) m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // drive one token word; inputs move on the falling edge, valid stays up
    // between back-to-back words and drops for a drawn gap or a wait for results
    task automatic send_token(input logic [1:0] kind, input word_t value,
                              input logic [2:0] opcode);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_IDLE);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= kind;
        s_operand_value <= value;
        s_opcode        <= opcode;
        do @(posedge aclk); while (!s_ready);
        eval_model.take_token(kind, value, opcode);
        // ignored words do not count toward the item total
        if (kind == KIND_OPERAND || kind == KIND_END
                || (kind == KIND_OPERATOR && opcode <= OP_MOD))
            token_count++;
    endtask

    // unused fields of each token still get random bits
    task automatic send_operand(input word_t value);
        send_token(KIND_OPERAND, value, 3'($urandom_range(0, 7)));
    endtask

    task automatic send_operator(input logic [2:0] op);
        send_token(KIND_OPERATOR, word_t'($urandom), op);
    endtask

    task automatic send_end();
        send_token(KIND_END, word_t'($urandom), 3'($urandom_range(0, 7)));
    endtask

    // a word the block must ignore: kind 3 or an undefined opcode
    task automatic send_noise();
        if ($urandom_range(0, 1) == 1)
            send_token(KIND_UNUSED, word_t'($urandom), 3'($urandom_range(0, 7)));
        else
            send_operator(3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI)));
    endtask

    task automatic wait_all_results();
        @(negedge aclk) s_valid <= 1'b0;
        while (eval_model.outstanding() != 0) @(posedge aclk);
    endtask

    // small values make zero divisors and exact divides common
    function automatic word_t pick_operand();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return -16'sd1;
            2:       return WORD_MIN;
            3:       return WORD_MAX;
            4, 5:    return word_t'($urandom_range(0, 20)) - 16'sd10;
            default: return word_t'($urandom);
        endcase
    endfunction

    // one expression followed by its end token; mostly well formed
    task automatic send_expression();
        int unsigned shape, n_ops, operands_left, ops_left, depth, n;
        shape = $urandom_range(0, 99);
        tx_burst = ($urandom_range(0, 4) == 0);
        if (shape < 80) begin
            // operands pushed whenever fewer than two are on the stack,
            // so every operator finds both of its operands
            n_ops = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 31)
                                                 : $urandom_range(0, 6);
            operands_left = n_ops + 1;
            ops_left = n_ops;
            depth = 0;
            while (operands_left + ops_left > 0) begin
                if ($urandom_range(0, 24) == 0) send_noise();
                if (operands_left > 0 && (depth < 2 || $urandom_range(0, 1) == 1)) begin
                    send_operand(pick_operand());
                    operands_left--;
                    depth++;
                end else begin
                    send_operator(3'($urandom_range(OP_ADD, OP_MOD)));
                    ops_left--;
                    depth--;
                end
            end
        end else if (shape < 90) begin
            // malformed: operators may run dry, operands may be left behind
            n = $urandom_range(1, 8);
            repeat (n) begin
                if ($urandom_range(0, 1) == 1) send_operand(pick_operand());
                else send_operator(3'($urandom_range(OP_ADD, OP_MOD)));
            end
        end else if (shape < 95) begin
            // push operands to near, at or past the stack depth
            n = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 4);
            repeat (n) send_operand(pick_operand());
            repeat ($urandom_range(0, 3)) send_operator(3'($urandom_range(OP_ADD, OP_MOD)));
        end else begin
            // raw noise of any kind and opcode
            repeat ($urandom_range(1, 5))
                send_token(2'($urandom_range(0, 3)), word_t'($urandom),
                           3'($urandom_range(0, 7)));
        end
        send_end();
    endtask

    initial begin
        eval_model = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // end token on an empty stack reports zero with underflow
        send_end();
        // extremes through add
        send_operand(WORD_MAX);
        send_operand(WORD_MIN);
        send_operator(OP_ADD);
        send_end();
        // most negative over minus one wraps back to most negative
        send_operand(-16'sd1);
        send_operand(WORD_MIN);
        send_operator(OP_DIV);
        send_end();
        // and its remainder is zero
        send_operand(-16'sd1);
        send_operand(WORD_MIN);
        send_operator(OP_MOD);
        send_end();
        // product wraps to zero; the value below it is dropped at the end
        send_operand(16'sd1);
        send_operand(WORD_MIN);
        send_operand(WORD_MIN);
        send_operator(OP_MUL);
        send_end();
        // ignored kind and opcode between the operands of a subtract
        send_operand(16'sd7);
        send_token(KIND_UNUSED, word_t'($urandom), OP_ADD);
        send_operand(16'sd3);
        send_operator(OP_UNDEF_HI);
        send_operator(OP_SUB);
        send_end();
        // modulo by zero, then an underflow that must not replace it
        send_operand(16'sd0);
        send_operand(16'sd1);
        send_operator(OP_MOD);
        send_operator(OP_ADD);
        send_end();
        wait_all_results();

        while (token_count < TX_ITEMS) begin
            // once, halfway: hold off until the result side has caught up
            if (!paused_once && token_count >= TX_ITEMS / 2) begin
                wait_all_results();
                paused_once = 1'b1;
            end
            send_expression();
        end
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("%0d token words over %0d cycles, %0d result words checked",
                 token_count, cycle_count, eval_model.checked_count);
        $display("expected codes: %0d ok, %0d div by zero, %0d overflow, %0d underflow",
                 eval_model.error_tally[ERR_NONE], eval_model.error_tally[ERR_DIV0],
                 eval_model.error_tally[ERR_OVER], eval_model.error_tally[ERR_UNDER]);
        if (eval_model.fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/pese_pkg.sv
hw/rtl/pese_div.sv
hw/rtl/pese_dp.sv
hw/rtl/pese_ctrl.sv
hw/rtl/prefix_expression_stack_evaluator.sv
bench/tb.sv
